// ===== rtl/gcm_ghash_tag_unit_macros.svh =====
// ---------------------------------------------------------------------------
// GHASH tag unit assertion macros
// Clocked implication helpers shared by the checker.
// ---------------------------------------------------------------------------
`ifndef GCM_GHASH_TAG_UNIT_MACROS_SVH
`define GCM_GHASH_TAG_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define GCMGH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gcmgh assertion failed");

// next-cycle implication, disabled while in reset
`define GCMGH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gcmgh assertion failed");

`endif

// ===== rtl/gcmgh_pkg.sv =====
// ---------------------------------------------------------------------------
// GHASH tag package
// Shared constants for the GHASH tag unit and its checker.
// ---------------------------------------------------------------------------
package gcmgh_pkg;

	localparam int BLK_W       = 128;
	localparam int HALF_W      = 64;
	localparam int BLOCK_BYTES = 16;
	localparam int CNT_W       = 5;

	// function codes on the input word
	localparam logic [1:0] FUNC_AAD    = 2'd0;
	localparam logic [1:0] FUNC_TEXT   = 2'd1;
	localparam logic [1:0] FUNC_FINISH = 2'd2;
	localparam logic [1:0] FUNC_NONE   = 2'd3;

	// configuration register indexes
	localparam logic REG_HASH_KEY_HI = 1'b0;
	localparam logic REG_HASH_KEY_LO = 1'b1;

	// reduction constant, GCM reflected bit order (x^0 at bit 127)
	localparam logic [BLK_W-1:0] GCM_R = {8'hE1, 120'd0};

	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(BLOCK_BYTES);

endpackage

// ===== rtl/gcm_ghash_tag_unit.sv =====
// ---------------------------------------------------------------------------
// GCM GHASH tag unit
// Absorbs AAD and ciphertext blocks into the GHASH accumulator and emits
// the authentication tag on finish.
// ---------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  input    | in_valid / in_stall | func, data_hi, data_lo, byte_count
//  output   | out_valid/out_stall | tag_hi, tag_lo
//  config   | cfg_we              | cfg_index, cfg_data
//
//  One word per cycle sustained while in_stall is low. Each word is held
//  in the input stage, where the combinational GF(2^128) multiply by H
//  updates the accumulator. A finish word goes on from the input stage to
//  the tag register; in_stall rises only while it waits behind a held tag.
//  Reset clears H, the accumulator and both bit-length counters.
// ---------------------------------------------------------------------------
module gcm_ghash_tag_unit
	import gcmgh_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [HALF_W-1:0] cfg_data,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        func,
	input  logic [HALF_W-1:0] data_hi,
	input  logic [HALF_W-1:0] data_lo,
	input  logic [CNT_W-1:0]  byte_count,
	// output channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [HALF_W-1:0] tag_hi,
	output logic [HALF_W-1:0] tag_lo
);

	// hash subkey
	logic [HALF_W-1:0] key_hi_q;
	logic [HALF_W-1:0] key_lo_q;

	// running state
	logic [BLK_W-1:0]  acc_q;
	logic [HALF_W-1:0] aad_len_q;
	logic [HALF_W-1:0] txt_len_q;

	// input stage
	logic              valid_s1;
	logic [1:0]        func_s1;
	logic [BLK_W-1:0]  data_s1;
	logic [CNT_W-1:0]  cnt_s1;

	// tag register
	logic              out_valid_q;
	logic [BLK_W-1:0]  tag_q;

	logic              is_data;
	logic              is_fin;
	logic              s1_go;
	logic              s1_load;
	logic [CNT_W-1:0]  n_sat;
	logic [BLK_W-1:0]  padded;
	logic [BLK_W-1:0]  mul_x;
	logic [BLK_W-1:0]  mul_z;
	logic [HALF_W-1:0] len_inc;

	// --- decode of the word held in the input stage -------------------------
	assign is_fin  = valid_s1 && (func_s1 == FUNC_FINISH);
	// zero-length data words and the unused code leave everything alone
	assign is_data = valid_s1 && ((func_s1 == FUNC_AAD) || (func_s1 == FUNC_TEXT))
		&& (cnt_s1 != '0);

	// a finish word can only move on once the tag register is free
	assign s1_go    = !(is_fin && out_valid_q && out_stall);
	assign s1_load  = !valid_s1 || s1_go;
	assign in_stall = !s1_load;

	// counts above a full block saturate
	assign n_sat = (cnt_s1 > FULL_COUNT) ? FULL_COUNT : cnt_s1;

	// zero bytes at and beyond the valid count; byte 0 is the top byte
	always_comb begin
		padded = data_s1;
		for (int i = 0; i < BLOCK_BYTES; i++) begin
			if (CNT_W'(i) >= n_sat) begin
				padded[BLK_W-1-8*i -: 8] = 8'h00;
			end
		end
	end

	// on finish the length block len(A) || len(C) is folded in
	assign mul_x   = acc_q ^ (is_fin ? {aad_len_q, txt_len_q} : padded);
	assign len_inc = {{(HALF_W-CNT_W-3){1'b0}}, n_sat, 3'b000};

	gcmgh_gf_mul u_mul (
		.x (mul_x),
		.y ({key_hi_q, key_lo_q}),
		.z (mul_z)
	);

	// --- configuration --------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HASH_KEY_HI: key_hi_q <= cfg_data;
				REG_HASH_KEY_LO: key_lo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// --- input stage ------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load && in_valid) begin
			func_s1 <= func;
			data_s1 <= {data_hi, data_lo};
			cnt_s1  <= byte_count;
		end
	end

	// --- accumulator and length counters ----------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			aad_len_q <= '0;
			txt_len_q <= '0;
		end else if (is_fin && s1_go) begin
			acc_q     <= '0;
			aad_len_q <= '0;
			txt_len_q <= '0;
		end else if (is_data) begin
			acc_q <= mul_z;
			if (func_s1 == FUNC_AAD) begin
				aad_len_q <= aad_len_q + len_inc;
			end else begin
				txt_len_q <= txt_len_q + len_inc;
			end
		end
	end

	// --- tag register -----------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!(out_valid_q && out_stall)) begin
			out_valid_q <= is_fin;
		end
	end

	// tag = GHASH ^ E(K,J0), the latter carried in the finish word's data
	always_ff @(posedge clk) begin
		if (is_fin && s1_go) begin
			tag_q <= mul_z ^ data_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign tag_hi    = tag_q[BLK_W-1:HALF_W];
	assign tag_lo    = tag_q[HALF_W-1:0];

endmodule

// ===== rtl/gcmgh_gf_mul.sv =====
// ---------------------------------------------------------------------------
// GF(2^128) multiplier
// Combinational carry-less product with GCM reduction, reflected bit order.
// ---------------------------------------------------------------------------
module gcmgh_gf_mul
	import gcmgh_pkg::*;
(
	input  logic [BLK_W-1:0] x,
	input  logic [BLK_W-1:0] y,
	output logic [BLK_W-1:0] z
);

	always_comb begin
		logic [BLK_W-1:0] acc;
		logic [BLK_W-1:0] v;
		logic             lsb;
		acc = '0;
		v   = y;
		for (int i = 0; i < BLK_W; i++) begin
			if (x[BLK_W-1-i]) begin
				acc = acc ^ v;
			end
			lsb = v[0];
			v   = v >> 1;
			if (lsb) begin
				v = v ^ GCM_R;
			end
		end
		z = acc;
	end

endmodule

// ===== rtl/gcmgh_checker.sv =====
// ---------------------------------------------------------------------------
// GHASH tag unit checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`include "gcm_ghash_tag_unit_macros.svh"

module gcmgh_checker
	import gcmgh_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic [1:0]        func,
	input logic              out_valid,
	input logic              out_stall,
	input logic [HALF_W-1:0] tag_hi,
	input logic [HALF_W-1:0] tag_lo
);

	// held tag stays up
	`GCMGH_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// held tag does not change
	`GCMGH_ASSERT_NXT(a_tag_stable, clk, arst_n, out_valid && out_stall,
		$stable(tag_hi) && $stable(tag_lo))

	// input back-pressure only comes from a held tag
	`GCMGH_ASSERT_IMP(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)

	// a fresh tag follows a finish word accepted on the input channel
	`GCMGH_ASSERT_IMP(a_tag_origin, clk, arst_n, $rose(out_valid),
		$past(in_valid && !in_stall && (func == FUNC_FINISH), 2))

endmodule

bind gcm_ghash_tag_unit gcmgh_checker u_gcmgh_checker (.*);
